[design/pdsa_pkg.sv]
// Shared types and constants for the pointer delta scaler.
package pdsa_pkg;

    // Request fields of one input event.
    typedef struct packed {
        logic [7:0]         event_kind;
        logic [15:0]        event_axis;
        logic signed [31:0] event_amount;
        logic               drag_scroll_active;
    } in_item_t;

    // Fields of one result event.
    typedef struct packed {
        logic [7:0]         out_kind;
        logic [15:0]        out_axis;
        logic signed [31:0] out_amount;
    } out_item_t;

    // Register map, index = paddr[4:2].
    typedef enum logic [2:0] {
        REG_GAIN_MUL  = 3'd0,
        REG_GAIN_DIV  = 3'd1,
        REG_SPEED     = 3'd2,
        REG_CURVE     = 3'd3,
        REG_DEAD_ZONE = 3'd4,
        REG_ACCEL_NUM = 3'd5,
        REG_ACCEL_DEN = 3'd6,
        REG_DELTA_CAP = 3'd7
    } reg_idx_t;

    localparam int unsigned PADDR_W = 5;

    localparam logic [7:0]  KIND_REL = 8'd2;
    localparam logic [15:0] AXIS_X   = 16'd0;
    localparam logic [15:0] AXIS_Y   = 16'd1;

    // Register reset values.
    localparam logic [15:0] GAIN_MUL_RST  = 16'd1;
    localparam logic [15:0] GAIN_DIV_RST  = 16'd1;
    localparam logic [23:0] SPEED_RST     = 24'd65536;
    localparam logic [15:0] ACCEL_NUM_RST = 16'd1;
    localparam logic [15:0] ACCEL_DEN_RST = 16'd1;

    // Divider: 72-bit dividend shift register, one quotient bit per step.
    localparam int unsigned DIV_W          = 72;
    localparam logic [6:0]  DIV_STEPS_SCALE = 7'd72;
    localparam logic [6:0]  DIV_STEPS_CURVE = 7'd48;
    localparam int unsigned CURVE_ALIGN     = 24;

    localparam logic [16:0] INT16_MAX_MAG = 17'd32767;
    localparam logic [16:0] INT16_MIN_MAG = 17'd32768;

endpackage

[design/pointer_delta_scale_accel.sv]
// Top level of the pointer delta scaler with adaptive acceleration curve.
//
// Relative X/Y motion requests (kind 2, axis 0 or 1, drag scroll off) are
// scaled by gain_multiplier * speed_factor / (gain_divisor * 65536) with a
// signed remainder carried from one request to the next, saturated to int16,
// and in adaptive mode boosted by (over^2 * accel_numerator) /
// accel_denominator above the dead zone, capped by delta_cap when nonzero.
// Every other request passes through unchanged. A scaled request spends most
// of its time in flight in the restoring divider, which yields one quotient
// bit per cycle (72 bits for the scale step, 48 for the curve step). One
// 32x32 multiplier is reused for all five products. in_stall stays high
// while a request is in flight; the result sits in an output register so
// the next request can be taken while the previous result is still stalled.
// Configure only while idle.
module pointer_delta_scale_accel (
    input  logic                              clk,
    input  logic                              rst_n,
    // input requests
    input  logic                              in_valid,
    output logic                              in_stall,
    input  pdsa_pkg::in_item_t                in_item,
    // results
    output logic                              out_valid,
    input  logic                              out_stall,
    output pdsa_pkg::out_item_t               out_item,
    // APB-style register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pdsa_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import pdsa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_B,
        ST_MUL_LO,
        ST_MUL_MID,
        ST_ADD_MID,
        ST_ADD_REM,
        ST_DIV,
        ST_SCALE_END,
        ST_CRV_SQ,
        ST_CRV_MUL,
        ST_CRV_LOAD,
        ST_CRV_END,
        ST_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] gain_mul_reg;
    logic [15:0] gain_div_reg;
    logic [23:0] speed_reg;
    logic        curve_mode_reg;
    logic [15:0] dead_zone_reg;
    logic [15:0] accel_num_reg;
    logic [15:0] accel_den_reg;
    logic [15:0] delta_cap_reg;

    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_mul_reg   <= GAIN_MUL_RST;
            gain_div_reg   <= GAIN_DIV_RST;
            speed_reg      <= SPEED_RST;
            curve_mode_reg <= 1'b0;
            dead_zone_reg  <= 16'd0;
            accel_num_reg  <= ACCEL_NUM_RST;
            accel_den_reg  <= ACCEL_DEN_RST;
            delta_cap_reg  <= 16'd0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GAIN_MUL:  gain_mul_reg   <= pwdata[15:0];
                REG_GAIN_DIV:  gain_div_reg   <= pwdata[15:0];
                REG_SPEED:     speed_reg      <= pwdata[23:0];
                REG_CURVE:     curve_mode_reg <= pwdata[0];
                REG_DEAD_ZONE: dead_zone_reg  <= pwdata[15:0];
                REG_ACCEL_NUM: accel_num_reg  <= pwdata[15:0];
                REG_ACCEL_DEN: accel_den_reg  <= pwdata[15:0];
                REG_DELTA_CAP: delta_cap_reg  <= pwdata[15:0];
                default:       gain_mul_reg   <= gain_mul_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GAIN_MUL:  prdata = {16'd0, gain_mul_reg};
            REG_GAIN_DIV:  prdata = {16'd0, gain_div_reg};
            REG_SPEED:     prdata = {8'd0, speed_reg};
            REG_CURVE:     prdata = {31'd0, curve_mode_reg};
            REG_DEAD_ZONE: prdata = {16'd0, dead_zone_reg};
            REG_ACCEL_NUM: prdata = {16'd0, accel_num_reg};
            REG_ACCEL_DEN: prdata = {16'd0, accel_den_reg};
            REG_DELTA_CAP: prdata = {16'd0, delta_cap_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t             state_reg,   state_next;
    logic [6:0]         cnt_reg,     cnt_next;
    logic               phase_reg,   phase_next;   // 0 scale divide, 1 curve divide
    logic signed [32:0] carry_reg,   carry_next;   // carried remainder
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg,  out_item_next;

    logic [7:0]         kind_reg,    kind_next;
    logic [15:0]        axis_reg,    axis_next;
    logic               neg_reg,     neg_next;     // sign of the motion value
    logic [31:0]        mag_reg,     mag_next;     // magnitude of the motion value
    logic [39:0]        b_reg,       b_next;       // gain_multiplier * speed_factor
    logic [63:0]        prod_reg,    prod_next;    // multiplier output
    logic [DIV_W-1:0]   acc_reg,     acc_next;     // dividend / quotient shifter
    logic [31:0]        rem_reg,     rem_next;     // partial remainder
    logic [31:0]        divisor_reg, divisor_next;
    logic               sneg_reg,    sneg_next;    // sign of the scaled sum
    logic [16:0]        smag_reg,    smag_next;    // magnitude of the scaled value
    logic [16:0]        over_reg,    over_next;    // excess over the dead zone
    logic [31:0]        res_reg,     res_next;

    // Shared multiplier.
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;

    always_comb
    begin
        case (state_reg)
            ST_MUL_B:
            begin
                mul_a = {16'd0, gain_mul_reg};
                mul_b = {8'd0, speed_reg};
            end
            ST_MUL_LO:
            begin
                mul_a = mag_reg;
                mul_b = prod_reg[31:0];
            end
            ST_MUL_MID:
            begin
                mul_a = mag_reg;
                mul_b = {24'd0, b_reg[39:32]};
            end
            ST_CRV_SQ:
            begin
                mul_a = {15'd0, over_reg};
                mul_b = {15'd0, over_reg};
            end
            ST_CRV_MUL:
            begin
                mul_a = prod_reg[31:0];
                mul_b = {16'd0, accel_num_reg};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Input decode.
    logic        in_scaled;
    logic [31:0] in_mag;

    assign in_scaled = (in_item.event_kind == KIND_REL) &&
                       ((in_item.event_axis == AXIS_X) || (in_item.event_axis == AXIS_Y)) &&
                       !in_item.drag_scroll_active;
    assign in_mag    = in_item.event_amount[31] ? (~in_item.event_amount + 32'd1)
                                                : in_item.event_amount;

    // Signed add of the product and the carried remainder, on magnitudes.
    logic             carry_neg;
    logic [32:0]      carry_abs;
    logic [DIV_W-1:0] r_wide;
    logic             same_sign, p_ge, p_zero, swap_ops;
    logic [DIV_W-1:0] add_x, add_y, sum_mag;
    logic             sum_neg;

    assign carry_neg = carry_reg[32];
    assign carry_abs = carry_neg ? (33'd0 - carry_reg) : carry_reg;
    assign r_wide    = {40'd0, carry_abs[31:0]};
    assign same_sign = (neg_reg == carry_neg);
    assign p_zero    = (acc_reg == '0);
    assign p_ge      = (acc_reg >= r_wide);
    assign swap_ops  = !same_sign && !p_ge;
    assign add_x     = swap_ops ? r_wide : acc_reg;
    assign add_y     = swap_ops ? acc_reg : r_wide;
    assign sum_mag   = same_sign ? (add_x + add_y) : (add_x - add_y);
    assign sum_neg   = p_zero ? carry_neg : (swap_ops ? carry_neg : neg_reg);

    // One restoring divide step.
    logic [32:0] div_shift;
    logic [33:0] div_diff;
    logic        div_qbit;

    assign div_shift = {rem_reg, acc_reg[DIV_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, divisor_reg};
    assign div_qbit  = !div_diff[33];

    // Saturate the scale quotient to int16 and decide on the curve.
    logic        q_hi_nz;
    logic [16:0] q_low;
    logic [16:0] scl_mag;
    logic        crv_go;

    assign q_hi_nz = |acc_reg[DIV_W-1:16];
    assign q_low   = {1'b0, acc_reg[15:0]};
    always_comb
    begin
        if (sneg_reg)
            scl_mag = (q_hi_nz || (q_low > INT16_MIN_MAG)) ? INT16_MIN_MAG : q_low;
        else
            scl_mag = (q_hi_nz || (q_low > INT16_MAX_MAG)) ? INT16_MAX_MAG : q_low;
    end
    assign crv_go = curve_mode_reg && (scl_mag != 17'd0) &&
                    (scl_mag > {1'b0, dead_zone_reg});

    // Curve tail: add, cap, restore sign and saturate.
    logic [47:0] crv_total, crv_capped;
    logic [31:0] crv_res;

    assign crv_total  = {31'd0, smag_reg} + acc_reg[47:0];
    assign crv_capped = ((delta_cap_reg != 16'd0) && (crv_total > {32'd0, delta_cap_reg}))
                        ? {32'd0, delta_cap_reg} : crv_total;
    always_comb
    begin
        if (sneg_reg)
            crv_res = (crv_capped > {31'd0, INT16_MIN_MAG}) ? (32'd0 - {15'd0, INT16_MIN_MAG})
                                                          : (32'd0 - crv_capped[31:0]);
        else
            crv_res = (crv_capped > {31'd0, INT16_MAX_MAG}) ? {15'd0, INT16_MAX_MAG}
                                                          : crv_capped[31:0];
    end

    logic [15:0] gain_div_eff, accel_den_eff;

    assign gain_div_eff  = (gain_div_reg == 16'd0) ? 16'd1 : gain_div_reg;
    assign accel_den_eff = (accel_den_reg == 16'd0) ? 16'd1 : accel_den_reg;

    // Next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        carry_next     = carry_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        kind_next      = kind_reg;
        axis_next      = axis_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        b_next         = b_reg;
        prod_next      = mul_p;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        sneg_next      = sneg_reg;
        smag_next      = smag_reg;
        over_next      = over_reg;
        res_next       = res_reg;

        // Drop the result once the consumer takes it.
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = in_item.event_kind;
                    axis_next = in_item.event_axis;
                    res_next  = in_item.event_amount;
                    neg_next  = in_item.event_amount[31];
                    mag_next  = in_mag;
                    state_next = in_scaled ? ST_MUL_B : ST_DONE;
                end
            end
            ST_MUL_B:
                state_next = ST_MUL_LO;
            ST_MUL_LO:
            begin
                b_next     = prod_reg[39:0];
                state_next = ST_MUL_MID;
            end
            ST_MUL_MID:
            begin
                acc_next   = {8'd0, prod_reg};
                state_next = ST_ADD_MID;
            end
            ST_ADD_MID:
            begin
                acc_next   = acc_reg + {prod_reg[39:0], 32'd0};
                state_next = ST_ADD_REM;
            end
            ST_ADD_REM:
            begin
                acc_next     = sum_mag;
                sneg_next    = sum_neg;
                rem_next     = 32'd0;
                divisor_next = {gain_div_eff, 16'd0};
                cnt_next     = DIV_STEPS_SCALE;
                phase_next   = 1'b0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                acc_next = {acc_reg[DIV_W-2:0], div_qbit};
                rem_next = div_qbit ? div_diff[31:0] : div_shift[31:0];
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    state_next = phase_reg ? ST_CRV_END : ST_SCALE_END;
            end
            ST_SCALE_END:
            begin
                carry_next = sneg_reg ? (33'd0 - {1'b0, rem_reg}) : {1'b0, rem_reg};
                smag_next  = scl_mag;
                over_next  = scl_mag - {1'b0, dead_zone_reg};
                res_next   = sneg_reg ? (32'd0 - {15'd0, scl_mag}) : {15'd0, scl_mag};
                state_next = crv_go ? ST_CRV_SQ : ST_DONE;
            end
            ST_CRV_SQ:
                state_next = ST_CRV_MUL;
            ST_CRV_MUL:
                state_next = ST_CRV_LOAD;
            ST_CRV_LOAD:
            begin
                acc_next     = {prod_reg[47:0], {CURVE_ALIGN{1'b0}}};
                rem_next     = 32'd0;
                divisor_next = {16'd0, accel_den_eff};
                cnt_next     = DIV_STEPS_CURVE;
                phase_next   = 1'b1;
                state_next   = ST_DIV;
            end
            ST_CRV_END:
            begin
                res_next   = crv_res;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{out_kind: kind_reg, out_axis: axis_reg,
                                       out_amount: res_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 7'd0;
            phase_reg     <= 1'b0;
            carry_reg     <= 33'sd0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            carry_reg     <= carry_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        axis_reg    <= axis_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        b_reg       <= b_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        sneg_reg    <= sneg_next;
        smag_reg    <= smag_next;
        over_reg    <= over_next;
        res_reg     <= res_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in flight");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ((divisor_reg != 32'd0) && (rem_reg < divisor_reg)))
        else $error("partial remainder not below divisor");

    a_carry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE_END) |=> (carry_abs[31:0] < divisor_reg) && !carry_abs[32])
        else $error("carried remainder exceeds divisor");

    a_curve_int16: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CRV_END) |=>
            (($signed(res_reg) >= -32'sd32768) && ($signed(res_reg) <= 32'sd32767)))
        else $error("curve result outside int16");

endmodule

[test/pdsa_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the pointer delta scaler: tracks registers, predicts and compares results.
module pdsa_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  pdsa_pkg::in_item_t           in_item,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  pdsa_pkg::out_item_t          out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdsa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    input  logic                         pready,
    output int                           fails,
    output int                           pending,
    output int                           checked
);
    import pdsa_pkg::*;

    // Shadow copy of the register file.
    logic [15:0] gain_mul;
    logic [15:0] gain_div;
    logic [23:0] speed;
    logic        curve_on;
    logic [15:0] dead_zone;
    logic [15:0] accel_num;
    logic [15:0] accel_den;
    logic [15:0] delta_cap;

    // Signed remainder carried between scaled events.
    longint      carry_rem;

    out_item_t   results_due_q[$];
    int          err_cnt;
    int          match_cnt;

    task automatic report_mismatch(input string what);
        err_cnt++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Exact rescale of one delta; updates the carried remainder.
    function automatic int scale_delta(input logic signed [31:0] amount);
        longint      amt;
        logic [79:0] amt_mag;
        logic [79:0] prod;
        logic [79:0] rem_mag;
        logic [79:0] sum_mag;
        logic [79:0] divisor;
        logic [79:0] quo;
        logic [79:0] rem_left;
        logic        amt_neg;
        logic        rem_neg;
        logic        sum_neg;
        amt     = amount;
        amt_neg = amt < 0;
        amt_mag = amt_neg ? 80'(-amt) : 80'(amt);
        prod    = amt_mag * 80'(gain_mul) * 80'(speed);
        rem_neg = carry_rem < 0;
        rem_mag = rem_neg ? 80'(-carry_rem) : 80'(carry_rem);
        if (prod == 80'd0) begin
            sum_mag = rem_mag;
            sum_neg = rem_neg;
        end
        else if (amt_neg == rem_neg) begin
            sum_mag = prod + rem_mag;
            sum_neg = amt_neg;
        end
        else if (prod >= rem_mag) begin
            sum_mag = prod - rem_mag;
            sum_neg = amt_neg;
        end
        else begin
            sum_mag = rem_mag - prod;
            sum_neg = rem_neg;
        end
        divisor   = 80'((gain_div == 16'd0) ? 16'd1 : gain_div) << 16;
        quo       = sum_mag / divisor;
        rem_left  = sum_mag % divisor;
        carry_rem = sum_neg ? -longint'(rem_left[63:0]) : longint'(rem_left[63:0]);
        if (quo >= 80'd32768)
            return sum_neg ? -32768 : 32767;
        return sum_neg ? -int'(quo[15:0]) : int'(quo[15:0]);
    endfunction

    // Quadratic boost above the dead zone, capped and saturated.
    function automatic int apply_curve(input int value);
        longint mag;
        longint over;
        longint boosted;
        longint den;
        if (curve_on != 1'b1 || value == 0)
            return value;
        mag = (value < 0) ? -longint'(value) : longint'(value);
        if (mag <= longint'(dead_zone))
            return value;
        den     = (accel_den == 16'd0) ? 64'sd1 : longint'(accel_den);
        over    = mag - longint'(dead_zone);
        boosted = mag + (over * over * longint'(accel_num)) / den;
        if (delta_cap != 16'd0 && boosted > longint'(delta_cap))
            boosted = longint'(delta_cap);
        if (value < 0)
            boosted = -boosted;
        if (boosted > 32767)
            return 32767;
        if (boosted < -32768)
            return -32768;
        return int'(boosted);
    endfunction

    function automatic out_item_t predict_event(input in_item_t req);
        out_item_t res;
        res.out_kind   = req.event_kind;
        res.out_axis   = req.event_axis;
        res.out_amount = req.event_amount;
        if (req.event_kind == KIND_REL && !req.drag_scroll_active &&
            (req.event_axis == AXIS_X || req.event_axis == AXIS_Y))
            res.out_amount = apply_curve(scale_delta(req.event_amount));
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            gain_mul  = GAIN_MUL_RST;
            gain_div  = GAIN_DIV_RST;
            speed     = SPEED_RST;
            curve_on  = 1'b0;
            dead_zone = '0;
            accel_num = ACCEL_NUM_RST;
            accel_den = ACCEL_DEN_RST;
            delta_cap = '0;
            carry_rem = 0;
            results_due_q.delete();
            pending <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_GAIN_MUL:  gain_mul  = pwdata[15:0];
                    REG_GAIN_DIV:  gain_div  = pwdata[15:0];
                    REG_SPEED:     speed     = pwdata[23:0];
                    REG_CURVE:     curve_on  = pwdata[0];
                    REG_DEAD_ZONE: dead_zone = pwdata[15:0];
                    REG_ACCEL_NUM: accel_num = pwdata[15:0];
                    REG_ACCEL_DEN: accel_den = pwdata[15:0];
                    REG_DELTA_CAP: delta_cap = pwdata[15:0];
                    default: ;
                endcase
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                results_due_q.push_back(predict_event(in_item));
            if (out_valid === 1'b1 && out_stall === 1'b0) begin
                if (results_due_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d axis %0d amount %0d",
                        out_item.out_kind, out_item.out_axis, $signed(out_item.out_amount)));
                end
                else begin
                    want = results_due_q.pop_front();
                    match_cnt++;
                    if (out_item.out_kind !== want.out_kind)
                        report_mismatch($sformatf("kind got %0d want %0d",
                            out_item.out_kind, want.out_kind));
                    if (out_item.out_axis !== want.out_axis)
                        report_mismatch($sformatf("axis got %0d want %0d",
                            out_item.out_axis, want.out_axis));
                    if (out_item.out_amount !== want.out_amount)
                        report_mismatch($sformatf("amount got %0d want %0d (kind %0d axis %0d)",
                            $signed(out_item.out_amount), $signed(want.out_amount),
                            want.out_kind, want.out_axis));
                end
            end
            pending <= results_due_q.size();
        end
        fails   <= err_cnt;
        checked <= match_cnt;
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Top of the pointer delta scaler testbench: stimulus, register writes and verdict.
module tb;
    import pdsa_pkg::*;

    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 67;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [31:0]          pwdata    = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int                   mismatches;
    int                   results_due;
    int                   results_checked;

    // Idle rates in percent for the sender and the receiver.
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   requests_sent  = 0;
    int                   settings_done  = 0;

    pointer_delta_scale_accel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    pdsa_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .fails     (mismatches),
        .pending   (results_due),
        .checked   (results_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure: redraw the stall every cycle at the current rate.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic in_item_t make_event(input logic [7:0] kind, input logic [15:0] axis,
                                            input logic [31:0] amount, input logic drag);
        in_item_t ev;
        ev.event_kind         = kind;
        ev.event_axis         = axis;
        ev.event_amount       = amount;
        ev.drag_scroll_active = drag;
        return ev;
    endfunction

    // Mostly well-formed motion with varied magnitudes; the rest is pass-through noise.
    function automatic in_item_t rand_event();
        int          pick;
        int          size_pick;
        logic [31:0] amount;
        logic [15:0] axis;
        pick      = $urandom_range(99);
        size_pick = $urandom_range(99);
        axis      = $urandom_range(1) ? AXIS_Y : AXIS_X;
        if (size_pick < 50)
            amount = 32'($urandom_range(400)) - 32'd200;
        else if (size_pick < 75)
            amount = 32'($urandom_range(80000)) - 32'd40000;
        else if (size_pick < 90)
            amount = $urandom;
        else begin
            case ($urandom_range(6))
                0: amount = 32'd0;
                1: amount = 32'd1;
                2: amount = 32'hFFFF_FFFF;
                3: amount = 32'd32767;
                4: amount = 32'hFFFF_8000;
                5: amount = 32'h7FFF_FFFF;
                default: amount = 32'h8000_0000;
            endcase
        end
        if (pick < 70)
            return make_event(KIND_REL, axis, amount, 1'b0);
        if (pick < 80)
            return make_event(KIND_REL, axis, amount, 1'b1);
        if (pick < 90)
            return make_event(KIND_REL, 16'($urandom), amount, 1'b0);
        return make_event(8'($urandom), 16'($urandom), $urandom, 1'($urandom));
    endfunction

    // Offer one request, idling at random first; hold it until accepted.
    task automatic send_request(input in_item_t ev);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        requests_sent++;
    endtask

    // Hold off new requests until every expected result is out and the block is free.
    task automatic drain_results();
        @(posedge clk);
        while (results_due != 0 || in_stall !== 1'b0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One APB write: setup then access. psel stays high between back-to-back writes.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] mul, input logic [31:0] div,
                                  input logic [31:0] spd, input logic [31:0] crv,
                                  input logic [31:0] dz, input logic [31:0] num,
                                  input logic [31:0] den, input logic [31:0] cap);
        write_reg(REG_GAIN_MUL, mul);
        write_reg(REG_GAIN_DIV, div);
        write_reg(REG_SPEED, spd);
        write_reg(REG_CURVE, crv);
        write_reg(REG_DEAD_ZONE, dz);
        write_reg(REG_ACCEL_NUM, num);
        write_reg(REG_ACCEL_DEN, den);
        write_reg(REG_DELTA_CAP, cap);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_done++;
    endtask

    initial
    begin
        int phase;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: unity scale, field extremes, int16 saturation edges.
        send_request(make_event(KIND_REL, AXIS_X, 32'd1, 1'b0));
        send_request(make_event(KIND_REL, AXIS_X, 32'hFFFF_FFFF, 1'b0));
        send_request(make_event(KIND_REL, AXIS_X, 32'd0, 1'b0));
        send_request(make_event(KIND_REL, AXIS_Y, 32'd32767, 1'b0));
        send_request(make_event(KIND_REL, AXIS_Y, 32'hFFFF_8000, 1'b0));
        send_request(make_event(KIND_REL, AXIS_X, 32'd32768, 1'b0));
        send_request(make_event(KIND_REL, AXIS_Y, 32'hFFFF_7FFF, 1'b0));
        send_request(make_event(KIND_REL, AXIS_X, 32'h7FFF_FFFF, 1'b0));
        send_request(make_event(KIND_REL, AXIS_X, 32'h8000_0000, 1'b0));
        // Pass-through: other axis, other kind, drag scroll on, all ones, all zeros.
        send_request(make_event(KIND_REL, 16'd2, 32'd12345, 1'b0));
        send_request(make_event(8'd3, AXIS_X, 32'd77, 1'b0));
        send_request(make_event(KIND_REL, AXIS_X, 32'hFFFF_FFFB, 1'b1));
        send_request(make_event(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        send_request(make_event(8'd0, 16'd0, 32'd0, 1'b0));
        in_valid <= 1'b0;
        drain_results();

        // Gain 3/2 leaves remainders; adaptive curve with a dead zone of 5, zero denominator.
        apply_settings(32'd3, 32'd2, 32'd65536, 32'd1, 32'd5, 32'd3, 32'd0, 32'd0);
        send_request(make_event(KIND_REL, AXIS_X, 32'd3, 1'b0));
        send_request(make_event(KIND_REL, AXIS_X, 32'd3, 1'b0));
        send_request(make_event(KIND_REL, AXIS_X, 32'd4, 1'b0));
        send_request(make_event(KIND_REL, AXIS_Y, 32'hFFFF_FFFD, 1'b0));
        send_request(make_event(KIND_REL, AXIS_X, 32'd0, 1'b0));
        send_request(make_event(KIND_REL, AXIS_X, 32'd40, 1'b0));
        send_request(make_event(KIND_REL, AXIS_X, 32'hFFFF_FFD8, 1'b0));
        send_request(make_event(KIND_REL, AXIS_Y, 32'd30000, 1'b0));
        send_request(make_event(KIND_REL, AXIS_Y, 32'd7, 1'b1));
        in_valid <= 1'b0;
        drain_results();

        // Same curve with a cap of 50.
        apply_settings(32'd3, 32'd2, 32'd65536, 32'd1, 32'd5, 32'd3, 32'd0, 32'd50);
        send_request(make_event(KIND_REL, AXIS_X, 32'd20, 1'b0));
        send_request(make_event(KIND_REL, AXIS_Y, 32'hFFFF_FFEC, 1'b0));
        in_valid <= 1'b0;

        // Random phases: each one drains, picks new settings and an idling mode.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (phase == 1)
                // Every register at its maximum: widest products.
                apply_settings(32'd65535, 32'd65535, 32'hFF_FFFF, 32'd1,
                               32'd65535, 32'd65535, 32'd65535, 32'd65535);
            else if (phase == 2)
                // Every register at zero: both divisors act as one, carry from before remains.
                apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
            else if (phase == 3)
                // Full speed and a steep uncapped curve: drive saturation.
                apply_settings(32'd1, 32'd0, 32'hFF_FFFF, 32'd1, 32'd0, 32'd65535, 32'd1, 32'd0);
            else if ($urandom_range(3) == 0)
                // Raw bus values: upper bits must be dropped.
                apply_settings($urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom);
            else
                apply_settings($urandom_range(1, 6), $urandom_range(0, 6),
                               $urandom_range(8192, 196608), $urandom_range(1),
                               $urandom_range(0, 30), $urandom_range(0, 10),
                               $urandom_range(0, 40),
                               $urandom_range(1) ? 0 : $urandom_range(1, 3000));
            repeat (ITEMS_PER_PHASE) send_request(rand_event());
            in_valid <= 1'b0;
        end

        // Wait out the last results, then give the curve path time to misbehave.
        drain_results();
        repeat (150) @(posedge clk);

        $display("Covered %0d requests and %0d checked results under %0d register settings,",
                 requests_sent, results_checked, settings_done);
        $display("with free-running, sender-idle, receiver-stall and mixed idling phases.");
        if (mismatches == 0 && results_due == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("Timed out with %0d results outstanding", results_due);
        $display("Regression FAIL");
        $finish;
    end

endmodule
